FILE: hdl/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg - shared constants and types for the integer square root pipeline
// Widths of the radicand, the remainder datapath and the root, plus the
// record that travels between pipeline stages.
// ----------------------------------------------------------------------------
package isr_pkg;

    localparam int INPUT_WIDTH = 32;
    // one root bit per step, two radicand bits consumed per step
    localparam int ROOT_STEPS  = (INPUT_WIDTH + 1) / 2;
    localparam int REM_W       = 2 * ROOT_STEPS;
    localparam int ROOT_WIDTH  = 16;
    localparam int S_TDATA_W   = ((INPUT_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((ROOT_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic             valid;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] acc;
    } isr_stage_t;

endpackage

FILE: hdl/isr_stage.sv
// ----------------------------------------------------------------------------
// isr_stage - one digit step of the restoring square root
// Tries the current probe against the remainder, updates remainder and
// partial root, and registers the result with its valid bit.
// ----------------------------------------------------------------------------
module isr_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic [isr_pkg::REM_W-1:0]  probe,
    input  isr_pkg::isr_stage_t        stage_in,
    output isr_pkg::isr_stage_t        stage_out
);
    import isr_pkg::*;

    logic [REM_W:0]   trial;
    logic             take;
    isr_stage_t       stage_next;
    logic             valid_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] acc_reg;

    always_comb begin
        trial           = {1'b0, stage_in.acc} + {1'b0, probe};
        take            = {1'b0, stage_in.rem} >= trial;
        stage_next.valid = stage_in.valid;
        if (take) begin
            stage_next.rem = stage_in.rem - trial[REM_W-1:0];
            stage_next.acc = (stage_in.acc >> 1) + probe;
        end else begin
            stage_next.rem = stage_in.rem;
            stage_next.acc = stage_in.acc >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_next.valid;
        end
    end

    // payload carries no reset
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= stage_next.rem;
            acc_reg <= stage_next.acc;
        end
    end

    always_comb begin
        stage_out.valid = valid_reg;
        stage_out.rem   = rem_reg;
        stage_out.acc   = acc_reg;
    end

endmodule

FILE: hdl/integer_square_root.sv
// ----------------------------------------------------------------------------
// integer_square_root - pipelined floor square root of an unsigned radicand
//
//   channel   dir   fields (tdata, low bit first)
//   s_        in    radicand [31:0]
//   m_        out   root     [15:0]
//
// One root bit is resolved per stage, and a result passes through every stage
// register before it leaves; a new radicand can enter every cycle unless a stall on m_ holds the pipeline.
// The last stage register holds the result for the m_ side.
// A stall on m_ while a result waits there freezes the whole pipeline, and
// s_tready drops with it.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module integer_square_root (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [isr_pkg::S_TDATA_W-1:0]  s_tdata,   // radicand
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [isr_pkg::M_TDATA_W-1:0]  m_tdata    // root
);
    import isr_pkg::*;

    isr_stage_t pipe [0:ROOT_STEPS];
    logic       pipe_en;

    assign pipe_en  = !pipe[ROOT_STEPS].valid || m_tready;
    assign s_tready = pipe_en;

    always_comb begin
        pipe[0].valid = s_tvalid;
        pipe[0].rem   = REM_W'(s_tdata[INPUT_WIDTH-1:0]);
        pipe[0].acc   = '0;
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++) begin : g_step
            localparam logic [REM_W-1:0] PROBE = REM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
            isr_stage u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (pipe_en),
                .probe     (PROBE),
                .stage_in  (pipe[k]),
                .stage_out (pipe[k+1])
            );
        end
    endgenerate

    assign m_tvalid = pipe[ROOT_STEPS].valid;
    assign m_tdata  = M_TDATA_W'(pipe[ROOT_STEPS].acc[ROOT_WIDTH-1:0]);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for integer_square_root
// Streams radicands into s_ in random bursts while m_ stalls on its own
// pattern, predicts every root with a bitwise restoring square root and
// compares each m_ transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    import isr_pkg::*;

    localparam int  CLK_HALF  = 5;
    localparam int  N_RANDOM  = 1700;
    localparam int  TAIL_CYC  = 40;
    localparam int  MAX_CYC   = 500000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic [INPUT_WIDTH-1:0] pending_radicands[$];
    logic [ROOT_WIDTH-1:0]  expected_roots[$];

    logic        s_taken    = 1'b0;  // s_ transaction completed at the last rising edge
    int          burst_left = 0;
    int          gap_left   = 0;
    int          rx_cycle   = 0;
    int          cycle_cnt  = 0;
    int          n_checked  = 0;
    int          n_errors   = 0;
    int          n_top_half = 0;

    integer_square_root uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // radicand
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // root
    );

    always #CLK_HALF aclk = ~aclk;

    // Restoring square root, one root bit per step, most significant first
    function automatic logic [ROOT_WIDTH-1:0] isqrt_floor(input logic [INPUT_WIDTH-1:0] radicand);
        logic [INPUT_WIDTH:0] rem;
        logic [INPUT_WIDTH:0] acc;
        logic [INPUT_WIDTH:0] probe;
        logic [INPUT_WIDTH:0] trial;
        rem   = {1'b0, radicand};
        acc   = '0;
        probe = {{(INPUT_WIDTH + 1 - 1){1'b0}}, 1'b1} << (2 * (ROOT_STEPS - 1));
        for (int step = 0; step < ROOT_STEPS; step++) begin
            trial = acc + probe;
            if (rem >= trial) begin
                rem = rem - trial;
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc[ROOT_WIDTH-1:0];
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_radicands.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_radicands.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? 80 : $urandom_range(0, 24);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: cycles through always-ready, random, sparse and long-stall phases
    always @(negedge aclk) begin
        rx_cycle++;
        case ((rx_cycle / 600) % 4)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (rx_cycle % 4) == 0;
            end
            default: begin
                m_tready <= ((rx_cycle / 8) % 4) == 0;
            end
        endcase
    end

    // Checks the result side first, then records the new prediction
    always @(posedge aclk) begin
        logic [ROOT_WIDTH-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected result transaction, root %0d", $time,
                         m_tdata[ROOT_WIDTH-1:0]);
                n_errors++;
            end else begin
                want = expected_roots.pop_front();
                n_checked++;
                if (m_tdata[ROOT_WIDTH-1:0] !== want) begin
                    $display("%0t: root mismatch, expected %0d, actual %0d", $time,
                             want, m_tdata[ROOT_WIDTH-1:0]);
                    n_errors++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_roots.push_back(isqrt_floor(s_tdata[INPUT_WIDTH-1:0]));
            if (s_tdata[INPUT_WIDTH-1]) n_top_half++;
            s_taken <= 1'b1;
        end else begin
            s_taken <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYC) begin
            $display("%0t: timeout, %0d roots still outstanding", $time, expected_roots.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [ROOT_WIDTH-1:0]  k;
        logic [INPUT_WIDTH-1:0] sq;

        // corner values: zero, tiny roots, square boundaries, single bits, all ones
        pending_radicands = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16,
                              32'd24, 32'd25, 32'h0000_FFFF, 32'h0001_0000,
                              32'h3FFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFE_0002,
                              32'hFFFF_FFFE, 32'hFFFF_FFFF};

        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    pending_radicands.push_back($urandom);
                end
                2: begin
                    // square and its immediate neighbours, where the floor flips
                    k  = ROOT_WIDTH'($urandom);
                    sq = k * k;
                    case ($urandom_range(0, 2))
                        0: pending_radicands.push_back(sq);
                        1: pending_radicands.push_back(sq - 1);
                        default: pending_radicands.push_back(sq + 1);
                    endcase
                end
                3: begin
                    pending_radicands.push_back($urandom >> $urandom_range(0, 31));
                end
                4: begin
                    pending_radicands.push_back($urandom_range(0, 300));
                end
                default: begin
                    pending_radicands.push_back(32'hFFFF_FFFF - $urandom_range(0, 200000));
                end
            endcase
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_radicands.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_roots.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);

        $display("Checked %0d roots (%0d radicands with the top bit set) under bursty input",
                 n_checked, n_top_half);
        $display("and a stalling receiver; %0d mismatches found.", n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
